FILE: hdl/aes_pkg.sv
package aes_pkg;

    typedef struct packed {
        logic        func;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_KLEN = 3'd4;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // start key expansion
        logic kexp;      // advance key schedule by one word
        logic start;     // apply first round key
        logic round;     // one cipher round
        logic last;      // this round is the final one
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] nr;  // round count
    } dp_stat_t;

    function automatic logic [7:0] xt(input logic [7:0] v);
        xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        isbox = t[x];
    endfunction

endpackage

FILE: hdl/aes_ram.sv
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/aes_datapath.sv
module aes_datapath (
    input  logic                aclk,
    input  logic [63:0]         key_word_zero,
    input  logic [63:0]         key_word_one,
    input  logic [63:0]         key_word_two,
    input  logic [63:0]         key_word_three,
    input  logic [1:0]          key_length_code,
    input  aes_pkg::in_item_t   in_item,
    input  aes_pkg::dp_cmd_t    cmd,
    output aes_pkg::dp_stat_t   stat,
    output logic [127:0]        state_out
);
    // Round keys are stored as 4-word rows of 128 bits, up to 15 rows in a 16-row RAM.
    logic [255:0] key_all;
    logic [3:0]   nk;
    logic [255:0] win_reg;     // last nk words, word 0 in top bits
    logic [5:0]   widx_reg;    // index of next word to produce
    logic [3:0]   modk_reg;    // widx mod nk
    logic [7:0]   rcon_reg;
    logic [127:0] row_reg;     // four words being gathered
    logic [1:0]   wpos_reg;
    logic         func_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] st_reg;

    logic         we;
    logic [3:0]   waddr;
    logic [3:0]   raddr;
    logic [127:0] rk;

    assign key_all = {key_word_zero, key_word_one, key_word_two, key_word_three};
    always_comb begin
        unique case (key_length_code)
            aes_pkg::KLEN_128: nk = 4'd4;
            aes_pkg::KLEN_192: nk = 4'd6;
            default:           nk = 4'd8;
        endcase
    end
    assign stat.nr = nk + 4'd6;

    // Key expansion: one word per cycle.
    logic [31:0] prev, wback, t, nw;
    always_comb begin
        prev = win_reg[255 - 32*(nk - 4'd1) -: 32];
        wback = win_reg[255 -: 32];
        t = prev;
        if (modk_reg == 4'd0)
            t = {aes_pkg::sbox(prev[23:16]) ^ rcon_reg, aes_pkg::sbox(prev[15:8]),
                 aes_pkg::sbox(prev[7:0]), aes_pkg::sbox(prev[31:24])};
        else if (nk == 4'd8 && modk_reg == 4'd4)
            t = {aes_pkg::sbox(prev[31:24]), aes_pkg::sbox(prev[23:16]),
                 aes_pkg::sbox(prev[15:8]), aes_pkg::sbox(prev[7:0])};
        nw = t ^ wback;
    end

    logic [31:0] cur_word;
    assign cur_word = (widx_reg < {2'b00, nk}) ? key_all[255 - 32*widx_reg[2:0] -: 32] : nw;

    logic [255:0] win_shift;
    always_comb begin
        win_shift = win_reg;
        for (int i = 0; i < 7; i++)
            if (i[3:0] < nk - 4'd1) win_shift[255-32*i -: 32] = win_reg[223-32*i -: 32];
        win_shift[255 - 32*(nk - 4'd1) -: 32] = cur_word;
    end

    assign we = cmd.kexp && (wpos_reg == 2'd3);
    assign waddr = widx_reg[5:2];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            widx_reg <= '0;
            modk_reg <= '0;
            rcon_reg <= 8'h01;
            wpos_reg <= '0;
        end else if (cmd.kexp) begin
            if (widx_reg >= {2'b00, nk}) begin
                if (modk_reg == 4'd0) rcon_reg <= aes_pkg::xt(rcon_reg);
            end
            win_reg <= win_shift;
            row_reg <= {row_reg[95:0], cur_word};
            wpos_reg <= wpos_reg + 2'd1;
            widx_reg <= widx_reg + 6'd1;
            modk_reg <= (modk_reg == nk - 4'd1) ? 4'd0 : modk_reg + 4'd1;
        end
    end

    aes_ram #(.Width(128), .Depth(16)) u_rk (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata({row_reg[95:0], cur_word}),
        .raddr(raddr), .rdata(rk)
    );

    // Round key address is set in the cycle before its use. Decryption starts with
    // the last row, which is written on the final expansion cycle and is still
    // held in the gather register, so the RAM only serves row 0 at that point.
    always_comb begin
        if (cmd.load || cmd.kexp)
            raddr = 4'd0;
        else if (cmd.start)
            raddr = func_reg ? stat.nr - 4'd1 : 4'd1;
        else
            raddr = func_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
    end

    // Round functions.
    logic [7:0] s [16];
    logic [7:0] a [16];
    logic [7:0] b [16];
    logic [127:0] enc, dec;
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = st_reg[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                a[4*c+r] = aes_pkg::sbox(s[r + 4*((c + r) % 4)]);
                b[r + 4*((c + r) % 4)] = aes_pkg::isbox(s[4*c+r]);
            end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                enc[127-8*(4*c+r) -: 8] = cmd.last ? a[4*c+r] :
                    aes_pkg::gmul(a[4*c+r], 8'h02) ^ aes_pkg::gmul(a[4*c+(r+1)%4], 8'h03) ^
                    a[4*c+(r+2)%4] ^ a[4*c+(r+3)%4];
            end
        dec = 128'(b[0]);
        for (int i = 0; i < 16; i++) dec[127-8*i -: 8] = b[i] ^ rk[127-8*i -: 8];
        for (int i = 0; i < 16; i++) b[i] = dec[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (!cmd.last)
                    dec[127-8*(4*c+r) -: 8] =
                        aes_pkg::gmul(b[4*c+r], 8'h0e) ^ aes_pkg::gmul(b[4*c+(r+1)%4], 8'h0b) ^
                        aes_pkg::gmul(b[4*c+(r+2)%4], 8'h0d) ^ aes_pkg::gmul(b[4*c+(r+3)%4], 8'h09);
    end

    // The round counter holds the row in use during each round cycle.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_item.func;
            st_reg <= {in_item.block_high, in_item.block_low};
        end else if (cmd.start) begin
            st_reg <= st_reg ^ (func_reg ? row_reg : rk);
            rnd_reg <= func_reg ? stat.nr - 4'd1 : 4'd1;
        end else if (cmd.round) begin
            st_reg <= func_reg ? dec : (enc ^ rk);
            rnd_reg <= func_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
        end
    end

    assign state_out = st_reg;
endmodule

FILE: hdl/aes_ctrl.sv
module aes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  aes_pkg::dp_stat_t stat,
    output aes_pkg::dp_cmd_t  cmd
);
    typedef enum logic [2:0] {ST_IDLE, ST_KEXP, ST_START, ST_ROUND, ST_DONE} state_t;
    state_t     state_reg;
    logic [5:0] cnt_reg;
    logic [5:0] kwords;

    assign kwords = 6'd4 * (6'(stat.nr) + 6'd1);

    always_comb begin
        cmd = '0;
        cmd.load  = in_fire;
        cmd.kexp  = (state_reg == ST_KEXP);
        cmd.start = (state_reg == ST_START);
        cmd.round = (state_reg == ST_ROUND);
        cmd.last  = (state_reg == ST_ROUND) && (cnt_reg == 6'(stat.nr) - 6'd1);
    end
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (in_fire) begin
                    state_reg <= ST_KEXP;
                    cnt_reg <= '0;
                end
                ST_KEXP: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == kwords - 6'd1) state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ST_ROUND;
                    cnt_reg <= '0;
                end
                ST_ROUND: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cmd.last) state_reg <= ST_DONE;
                end
                ST_DONE: if (out_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/aes_block_cipher_top.sv
// Sequence: key expansion of 4*(Nr+1) words, one key add step and Nr rounds
// run from accepted input to a valid result.
// Throughput: one block at a time; the next is taken after the result leaves.
// The round keys are expanded one word a cycle into a 16-row key RAM.
// Reset (aresetn low, synchronous) clears the controller and the key and key length registers.
module aes_block_cipher_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aes_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output aes_pkg::out_item_t    m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]  klen_reg;
    aes_pkg::dp_cmd_t  cmd;
    aes_pkg::dp_stat_t stat;
    logic [127:0]      st;

    // Configuration writes are always taken; an unknown index is ignored.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            klen_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                aes_pkg::CFG_KEY0: key0_reg <= cfg_data;
                aes_pkg::CFG_KEY1: key1_reg <= cfg_data;
                aes_pkg::CFG_KEY2: key2_reg <= cfg_data;
                aes_pkg::CFG_KEY3: key3_reg <= cfg_data;
                aes_pkg::CFG_KLEN: klen_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_valid && s_ready), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    aes_datapath u_dp (
        .aclk(aclk), .key_word_zero(key0_reg), .key_word_one(key1_reg),
        .key_word_two(key2_reg), .key_word_three(key3_reg), .key_length_code(klen_reg),
        .in_item(s_data), .cmd(cmd), .stat(stat), .state_out(st)
    );

    // The state register holds the result until the output transaction completes.
    assign m_data = {st[127:64], st[63:0]};
endmodule
